@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl of the 3-d hilbert/morton converter
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define HM3C_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// next-cycle implication, disabled during reset
`define HM3C_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define HM3C_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define HM3C_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/hm3c_pkg.sv @@
// types, constants, orientation tables and digit functions of the converter
// no dependencies; used by the interfaces, the cell and the top level
package hm3c_pkg;

  localparam int CODE_W        = 30;
  localparam int LEVEL_W       = 4;
  localparam int DIGIT_W       = 3;
  localparam int MAX_LEVEL_DEF = 9;

  // direction register codes
  localparam logic DIR_M2H = 1'b0;
  localparam logic DIR_H2M = 1'b1;

  // transform entry: bit 0 select, bit 1 invert
  localparam logic [1:0] ENTRY_ZERO = 2'd0;
  localparam logic [1:0] ENTRY_PASS = 2'd1;

  typedef logic [1:0]         entry_t;
  typedef entry_t [2:0][2:0]  xform_t;   // [row][col]
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [0:2][1:0]    perm_t;    // source line for each new line
  typedef logic [0:2]         flip_t;    // invert toggle for each new line

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [LEVEL_W-1:0] lvl;
    xform_t             xform;
    logic [CODE_W-1:0]  acc;
  } stage_t;

  // orientation updates, indexed by digit
  localparam perm_t M2H_SRC [8] = '{
    '{2'd2, 2'd1, 2'd0}, '{2'd2, 2'd0, 2'd1}, '{2'd2, 2'd0, 2'd1}, '{2'd1, 2'd0, 2'd2},
    '{2'd1, 2'd0, 2'd2}, '{2'd2, 2'd0, 2'd1}, '{2'd2, 2'd0, 2'd1}, '{2'd2, 2'd1, 2'd0}
  };
  localparam flip_t M2H_FLIP [8] = '{
    3'b000, 3'b000, 3'b000, 3'b110, 3'b110, 3'b101, 3'b101, 3'b101
  };
  localparam perm_t H2M_SRC [8] = '{
    '{2'd2, 2'd1, 2'd0}, '{2'd2, 2'd0, 2'd1}, '{2'd1, 2'd0, 2'd2}, '{2'd2, 2'd0, 2'd1},
    '{2'd2, 2'd1, 2'd0}, '{2'd2, 2'd0, 2'd1}, '{2'd1, 2'd0, 2'd2}, '{2'd2, 2'd0, 2'd1}
  };
  localparam flip_t H2M_FLIP [8] = '{
    3'b000, 3'b000, 3'b110, 3'b000, 3'b101, 3'b101, 3'b110, 3'b101
  };

  function automatic xform_t ident_xform();
    xform_t t;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        t[i][j] = (i == j) ? ENTRY_PASS : ENTRY_ZERO;
      end
    end
    return t;
  endfunction

  // output bit i is the or of the row-i entries applied to the digit bits
  function automatic digit_t apply_xform(xform_t t, digit_t d);
    digit_t res;
    logic   b;
    for (int i = 0; i < 3; i++) begin
      b = 1'b0;
      for (int j = 0; j < 3; j++) begin
        b = b | ((d[j] & t[i][j][0]) ^ (t[i][j][1] & t[i][j][0]));
      end
      res[i] = b;
    end
    return res;
  endfunction

  function automatic digit_t inv_gray(digit_t v);
    return {v[2], v[2] ^ v[1], v[2] ^ v[1] ^ v[0]};
  endfunction

  function automatic digit_t gray(digit_t d);
    return d ^ (d >> 1);
  endfunction

  // rows permuted for morton to hilbert, columns for hilbert to morton
  function automatic xform_t update_xform(xform_t t, digit_t sel, logic rows);
    xform_t n;
    perm_t  src;
    flip_t  fl;
    src = rows ? M2H_SRC[sel] : H2M_SRC[sel];
    fl  = rows ? M2H_FLIP[sel] : H2M_FLIP[sel];
    for (int k = 0; k < 3; k++) begin
      for (int m = 0; m < 3; m++) begin
        if (rows) begin
          n[k][m] = t[src[k]][m] ^ {fl[k], 1'b0};
        end else begin
          n[m][k] = t[m][src[k]] ^ {fl[k], 1'b0};
        end
      end
    end
    return n;
  endfunction

endpackage

@@ rtl/hm3c_in_if.sv @@
// input channel of the converter: valid/ready plus code and tree level
// depends on hm3c_pkg
interface hm3c_in_if import hm3c_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  code_in;
  logic [LEVEL_W-1:0] tree_level;

  modport source (output valid, output code_in, output tree_level, input ready);
  modport sink   (input valid, input code_in, input tree_level, output ready);
endinterface

@@ rtl/hm3c_out_if.sv @@
// result channel of the converter: valid/ready plus converted code
// depends on hm3c_pkg
interface hm3c_out_if import hm3c_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_out;

  modport source (output valid, output code_out, input ready);
  modport sink   (input valid, input code_out, output ready);
endinterface

@@ rtl/hilbert_morton_3d_convert_core.sv @@
// top level of the 3-d octree code converter (morton <-> hilbert order)
// depends on hm3c_pkg, hm3c_in_if, hm3c_out_if, hm3c_cell, assert_macros.svh
`include "assert_macros.svh"

// the block takes one word per cycle while the chain is not held by a stalled
// out_word and returns each converted word at the end of the cell chain: one
// cell per octal digit, most significant digit in the first cell, each cell
// holding the orientation transform and the partial result of one word and
// handing them on to its neighbor. a stalled result stops only the cells
// that are full, so bubbles in the chain still fill while out_word waits.
// tree_level above MAX_LEVEL is treated as MAX_LEVEL, code bits above the
// converted digits are ignored and come out as zero. cfg_wdata (direction)
// is taken whenever cfg_we is high and is meant to change only while no
// word is in the chain: 0 converts morton to hilbert, 1 converts hilbert to
// morton; reset value 0.
module hilbert_morton_3d_convert_core import hm3c_pkg::*; #(
  parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  hm3c_in_if.sink     in_word,
  hm3c_out_if.source  out_word
);

  localparam int NCELL = MAX_LEVEL + 1;

  logic               direction_r;
  logic [NCELL:0]     v;
  logic [NCELL:0]     rdy;
  stage_t             data [NCELL+1];
  logic [LEVEL_W-1:0] lvl_sat;
  logic [5:0]         used_bits;
  logic               upper_clear;

  // direction register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_M2H;
    end else if (cfg_we) begin
      direction_r <= cfg_wdata;
    end
  end

  // saturate the level and seed the chain with identity orientation
  always_comb begin
    lvl_sat = (in_word.tree_level > LEVEL_W'(MAX_LEVEL)) ? LEVEL_W'(MAX_LEVEL)
                                                        : in_word.tree_level;
    data[0].code  = in_word.code_in;
    data[0].lvl   = lvl_sat;
    data[0].xform = ident_xform();
    data[0].acc   = '0;
  end

  assign v[0]          = in_word.valid;
  assign in_word.ready = rdy[0];

  // cell c converts digit position MAX_LEVEL-c; cells above the level pass through
  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    hm3c_cell #(
      .POS(MAX_LEVEL - c)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .direction(direction_r),
      .up_valid (v[c]),
      .up_ready (rdy[c]),
      .up_data  (data[c]),
      .dn_valid (v[c+1]),
      .dn_ready (rdy[c+1]),
      .dn_data  (data[c+1])
    );
  end

  // the last cell's register is the output register
  assign out_word.valid    = v[NCELL];
  assign rdy[NCELL]        = out_word.ready;
  assign out_word.code_out = data[NCELL].acc;

  // bits above the converted digits must be zero
  assign used_bits   = 6'({data[NCELL].lvl, 1'b0}) + 6'(data[NCELL].lvl) + 6'(DIGIT_W);
  assign upper_clear = ((out_word.code_out >> used_bits) == '0);

  // input back-pressure only when the whole chain is full and the output stalls
  `HM3C_ASSERT_IMPL(a_stall_from_out, clk, rst_n, !in_word.ready, out_word.valid && !out_word.ready)
  // the first cell keeps its word while it cannot move on
  `HM3C_ASSERT_NEXT(a_first_cell_holds, clk, rst_n, v[1] && !rdy[1], v[1])
  // converted word carries nothing above its digits
  `HM3C_ASSERT_IMPL(a_upper_bits_zero, clk, rst_n, out_word.valid, upper_clear)

endmodule

@@ rtl/hm3c_cell.sv @@
// one cell of the converter chain: converts the digit at position POS
// depends on hm3c_pkg
module hm3c_cell import hm3c_pkg::*; #(
  parameter int POS = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   direction,
  input  logic   up_valid,
  output logic   up_ready,
  input  stage_t up_data,
  output logic   dn_valid,
  input  logic   dn_ready,
  output stage_t dn_data
);

  logic   v_r;
  stage_t data_r;
  stage_t data_nxt;
  logic   active;
  digit_t digit;
  digit_t res;
  digit_t sel;

  always_comb begin
    active = (up_data.lvl >= LEVEL_W'(POS));
    digit  = up_data.code[DIGIT_W*POS +: DIGIT_W];
    if (direction == DIR_M2H) begin
      res = inv_gray(apply_xform(up_data.xform, digit));
      sel = res;
    end else begin
      sel = gray(digit);
      res = apply_xform(up_data.xform, sel);
    end
    data_nxt = up_data;
    if (active) begin
      data_nxt.acc = {up_data.acc[CODE_W-DIGIT_W-1:0], res};
      // the last digit leaves the orientation alone
      if (POS > 0) begin
        data_nxt.xform = update_xform(up_data.xform, sel, direction == DIR_M2H);
      end
    end
  end

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule
